@@ rtl/infix_expression_evaluator_top_defines.svh @@
// assertion macros for the expression evaluator
`ifndef INFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// assert that a condition holds at every clock edge outside reset
`define IEE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// assert that an antecedent implies a consequent in the next cycle
`define IEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/iee_pkg.sv @@
`default_nettype none
package iee_pkg;

  // character classes
  localparam logic [2:0] CLS_NONE  = 3'd0;
  localparam logic [2:0] CLS_DIGIT = 3'd1;
  localparam logic [2:0] CLS_OP    = 3'd2;
  localparam logic [2:0] CLS_OPEN  = 3'd3;
  localparam logic [2:0] CLS_CLOSE = 3'd4;
  localparam logic [2:0] CLS_BAD   = 3'd5;

  // operator codes
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_OPEN = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADCHAR = 3'd1;
  localparam logic [2:0] ST_BRACKET = 3'd2;
  localparam logic [2:0] ST_OPERR   = 3'd3;
  localparam logic [2:0] ST_ADJ     = 3'd4;
  localparam logic [2:0] ST_DIVZERO = 3'd5;
  localparam logic [2:0] ST_OVF     = 3'd6;

  // ascii codes
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // operation request to the arithmetic unit
  typedef struct packed {
    logic       start;
    logic [2:0] op;
  } alu_req_t;

  // arithmetic unit response
  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

  // error rank, lower is stronger
  function automatic logic [2:0] rank_of(input logic [2:0] code);
    logic [2:0] r;
    if (code <= 3'd2) r = code;
    else if (code <= 3'd4) r = 3'd3;
    else r = 3'd4;
    return r;
  endfunction

  // merged error code after flagging a new one
  function automatic logic [2:0] flag_err(input logic [2:0] cur, input logic [2:0] code);
    logic [2:0] r;
    r = cur;
    if (cur == ST_OK || rank_of(code) < rank_of(cur)) r = code;
    return r;
  endfunction

  // operator priority
  function automatic logic [1:0] prio(input logic [2:0] op);
    logic [1:0] p;
    if (op == OP_ADD || op == OP_SUB) p = 2'd1;
    else if (op == OP_MUL || op == OP_DIV) p = 2'd2;
    else p = 2'd0;
    return p;
  endfunction

endpackage
`default_nettype wire

@@ rtl/infix_expression_evaluator_top.sv @@
// a digit or '(' holds in_stall after its transfer through S_DISP and S_FINAL
// an operator or ')' holds it through S_PEEK and S_DECIDE, plus a pass per stacked operator reduced
// a division reduction also waits in S_WAIT for the bit-serial divider
// the last character also drains each leftover '(' and pending reduction before S_RD0 and S_OUT
// throughput: one character at a time; in_stall is high until the character is done
// reset: rst_n synchronous active low clears control state; stacks are not cleared
`default_nettype none
`include "infix_expression_evaluator_top_defines.svh"
module infix_expression_evaluator_top #(
  parameter int STACK_DEPTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_in,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_value,
  output logic [2:0]       out_status
);
  import iee_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int TW = $clog2(STACK_DEPTH + 1);
  localparam int VW = VALUE_WIDTH;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_PEEK   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_RDB    = 4'd4;
  localparam logic [3:0] S_RDA    = 4'd5;
  localparam logic [3:0] S_GO     = 4'd6;
  localparam logic [3:0] S_WAIT   = 4'd7;
  localparam logic [3:0] S_FINAL  = 4'd8;
  localparam logic [3:0] S_RD0    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  // loop modes
  localparam logic [1:0] M_OP    = 2'd0;
  localparam logic [1:0] M_CLOSE = 2'd1;
  localparam logic [1:0] M_END   = 2'd2;

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [TW-1:0] otop_r, otop_nxt;
  logic [TW-1:0] vtop_r, vtop_nxt;
  logic [2:0]    prev_r, prev_nxt;
  logic [31:0]   depth_r, depth_nxt;
  logic [2:0]    err_r, err_nxt;
  logic [2:0]    cls_r, cls_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [VW-1:0] digit_r, digit_nxt;
  logic          last_r, last_nxt;
  logic [2:0]    aop_r, aop_nxt;
  logic [VW-1:0] opa_r, opa_nxt;
  logic [VW-1:0] opb_r, opb_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [31:0]   oval_r, oval_nxt;
  logic [2:0]    ostat_r, ostat_nxt;
  logic          go_r;

  // stacks
  logic [2:0]    ostk [STACK_DEPTH];
  logic [VW-1:0] vstk [STACK_DEPTH];
  logic [2:0]    ord_r;
  logic [VW-1:0] vrd_r;
  logic          owe, vwe;
  logic [AW-1:0] owa, vwa, ora, vra;
  logic [2:0]    owd;
  logic [VW-1:0] vwd;

  alu_req_t      areq;
  alu_rsp_t      arsp;
  logic [VW-1:0] ares;

  logic [2:0]    ccls;
  logic [2:0]    cop;
  logic [2:0]    cerr;
  logic [31:0]   cdepth;

  iee_alu #(.VW(VW)) u_alu (
    .clk(clk), .rst_n(rst_n), .req(areq), .a(opa_r), .b(opb_r),
    .rsp(arsp), .result(ares)
  );

  // character classification
  always_comb begin
    cop = 3'd0;
    if (in_char_in >= CH_ZERO && in_char_in <= CH_NINE) ccls = CLS_DIGIT;
    else if (in_char_in == CH_ADD) begin ccls = CLS_OP; cop = OP_ADD; end
    else if (in_char_in == CH_SUB) begin ccls = CLS_OP; cop = OP_SUB; end
    else if (in_char_in == CH_MUL) begin ccls = CLS_OP; cop = OP_MUL; end
    else if (in_char_in == CH_DIV) begin ccls = CLS_OP; cop = OP_DIV; end
    else if (in_char_in == CH_OPEN) ccls = CLS_OPEN;
    else if (in_char_in == CH_CLOSE) ccls = CLS_CLOSE;
    else ccls = CLS_BAD;
  end

  // syntax checks on the incoming character
  always_comb begin
    cerr   = err_r;
    cdepth = depth_r;
    unique case (ccls)
      CLS_BAD: cerr = flag_err(err_r, ST_BADCHAR);
      CLS_DIGIT: if (prev_r == CLS_DIGIT) cerr = flag_err(err_r, ST_ADJ);
      CLS_OP:
        if (prev_r == CLS_NONE || prev_r == CLS_OP || prev_r == CLS_OPEN)
          cerr = flag_err(err_r, ST_OPERR);
      CLS_OPEN: if (depth_r != 32'hFFFF_FFFF) cdepth = depth_r + 32'd1;
      default:
        if (depth_r == 32'd0) cerr = flag_err(err_r, ST_BRACKET);
        else cdepth = depth_r - 32'd1;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    otop_nxt   = otop_r;
    vtop_nxt   = vtop_r;
    prev_nxt   = prev_r;
    depth_nxt  = depth_r;
    err_nxt    = err_r;
    cls_nxt    = cls_r;
    op_nxt     = op_r;
    digit_nxt  = digit_r;
    last_nxt   = last_r;
    aop_nxt    = aop_r;
    opa_nxt    = opa_r;
    opb_nxt    = opb_r;
    ovalid_nxt = ovalid_r;
    oval_nxt   = oval_r;
    ostat_nxt  = ostat_r;
    owe = 1'b0; owa = '0; owd = '0;
    vwe = 1'b0; vwa = '0; vwd = '0;
    ora = '0; vra = '0;
    areq.start = go_r;
    areq.op    = aop_r;
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cls_nxt   = ccls;
          op_nxt    = cop;
          digit_nxt = VW'(in_char_in - CH_ZERO);
          last_nxt  = in_last;
          err_nxt   = cerr;
          depth_nxt = cdepth;
          prev_nxt  = ccls;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (err_r != ST_OK) state_nxt = S_FINAL;
        else begin
          unique case (cls_r)
            CLS_DIGIT: begin
              if (vtop_r >= TW'(STACK_DEPTH))
                err_nxt = flag_err(err_r, ST_OVF);
              else begin
                vwe = 1'b1; vwa = AW'(vtop_r); vwd = digit_r;
                vtop_nxt = vtop_r + 1'b1;
              end
              state_nxt = S_FINAL;
            end
            CLS_OPEN: begin
              if (otop_r >= TW'(STACK_DEPTH)) err_nxt = flag_err(err_r, ST_OVF);
              else begin
                owe = 1'b1; owa = AW'(otop_r); owd = OP_OPEN;
                otop_nxt = otop_r + 1'b1;
              end
              state_nxt = S_FINAL;
            end
            CLS_CLOSE: begin mode_nxt = M_CLOSE; state_nxt = S_PEEK; end
            CLS_OP:    begin mode_nxt = M_OP;    state_nxt = S_PEEK; end
            default: state_nxt = S_FINAL;
          endcase
        end
      end
      S_PEEK: begin
        // read top operator
        if (err_r != ST_OK || otop_r == '0) state_nxt = S_DECIDE;
        else begin
          ora = AW'(otop_r - 1'b1);
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // keep the top operator on the read port for the pop
        ora = AW'(otop_r - 1'b1);
        if (err_r != ST_OK) state_nxt = S_FINAL;
        else if (otop_r == '0) begin
          if (mode_r == M_OP) begin
            owe = 1'b1; owa = AW'(otop_r); owd = op_r;
            otop_nxt = otop_r + 1'b1;
          end
          state_nxt = S_FINAL;
        end else begin
          unique case (mode_r)
            M_OP: begin
              if (prio(ord_r) >= prio(op_r)) state_nxt = S_RDB;
              else if (otop_r >= TW'(STACK_DEPTH)) begin
                err_nxt = flag_err(err_r, ST_OVF);
                state_nxt = S_FINAL;
              end else begin
                owe = 1'b1; owa = AW'(otop_r); owd = op_r;
                otop_nxt = otop_r + 1'b1;
                state_nxt = S_FINAL;
              end
            end
            M_CLOSE: begin
              if (ord_r == OP_OPEN) begin
                otop_nxt = otop_r - 1'b1;
                state_nxt = S_FINAL;
              end else state_nxt = S_RDB;
            end
            default: begin
              if (ord_r == OP_OPEN) begin
                otop_nxt = otop_r - 1'b1;
                state_nxt = S_PEEK;
              end else state_nxt = S_RDB;
            end
          endcase
        end
      end
      S_RDB: begin
        // pop operator and fetch right operand
        aop_nxt  = ord_r;
        otop_nxt = otop_r - 1'b1;
        if (vtop_r < TW'(2)) begin
          err_nxt = flag_err(err_r, ST_OPERR);
          state_nxt = (mode_r == M_END) ? S_FINAL : S_PEEK;
        end else begin
          vra = AW'(vtop_r - 1'b1);
          state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        opb_nxt = vrd_r;
        vra = AW'(vtop_r - TW'(2));
        state_nxt = S_GO;
      end
      S_GO: begin
        opa_nxt = vrd_r;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (arsp.done) begin
          if (arsp.div_zero) begin
            err_nxt = flag_err(err_r, ST_DIVZERO);
            vtop_nxt = vtop_r - TW'(2);
          end else begin
            vwe = 1'b1; vwa = AW'(vtop_r - TW'(2)); vwd = ares;
            vtop_nxt = vtop_r - 1'b1;
          end
          aop_nxt = 3'd0;
          state_nxt = (mode_r == M_END) ? S_PEEK : S_PEEK;
        end
      end
      S_FINAL: begin
        if (!last_r) state_nxt = S_IDLE;
        else if (mode_r != M_END) begin
          if (prev_r == CLS_OP || prev_r == CLS_NONE) err_nxt = flag_err(err_r, ST_OPERR);
          if (depth_r != 32'd0) err_nxt = flag_err(err_nxt, ST_BRACKET);
          mode_nxt = M_END;
          state_nxt = S_PEEK;
        end else begin
          if (err_r == ST_OK && vtop_r != TW'(1)) err_nxt = flag_err(err_r, ST_OPERR);
          vra = '0;
          state_nxt = S_RD0;
        end
      end
      S_RD0: state_nxt = S_OUT;
      S_OUT: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = err_r;
          oval_nxt   = (err_r == ST_OK) ? 32'(signed'(vrd_r)) : 32'd0;
          otop_nxt = '0; vtop_nxt = '0; prev_nxt = CLS_NONE;
          depth_nxt = '0; err_nxt = ST_OK; mode_nxt = M_OP; last_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // launch the shared unit as the operands are latched, in the cycle after S_GO
  always_ff @(posedge clk) begin
    if (!rst_n) go_r <= 1'b0;
    else go_r <= (state_r == S_GO);
  end

  // stack memories
  always_ff @(posedge clk) begin
    if (owe) ostk[owa] <= owd;
    if (vwe) vstk[vwa] <= vwd;
    ord_r <= ostk[ora];
    vrd_r <= vstk[vra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= M_OP;
      otop_r   <= '0;
      vtop_r   <= '0;
      prev_r   <= CLS_NONE;
      depth_r  <= '0;
      err_r    <= ST_OK;
      last_r   <= 1'b0;
      ovalid_r <= 1'b0;
      aop_r    <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      otop_r   <= otop_nxt;
      vtop_r   <= vtop_nxt;
      prev_r   <= prev_nxt;
      depth_r  <= depth_nxt;
      err_r    <= err_nxt;
      last_r   <= last_nxt;
      ovalid_r <= ovalid_nxt;
      aop_r    <= go_r ? aop_r : aop_nxt;
    end
    cls_r   <= cls_nxt;
    op_r    <= op_nxt;
    digit_r <= digit_nxt;
    opa_r   <= opa_nxt;
    opb_r   <= opb_nxt;
    oval_r  <= oval_nxt;
    ostat_r <= ostat_nxt;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = ovalid_r;
  assign out_value  = oval_r;
  assign out_status = ostat_r;

  // checks
  `IEE_ASSERT_ALWAYS(a_otop_bound, otop_r <= TW'(STACK_DEPTH), "operator stack past depth")
  `IEE_ASSERT_ALWAYS(a_vtop_bound, vtop_r <= TW'(STACK_DEPTH), "value stack past depth")
  `IEE_ASSERT_NEXT(a_out_idle, out_valid && !out_stall, !out_valid || state_r == S_IDLE,
    "result repeated")
  `IEE_ASSERT_ALWAYS(a_status_ok, !out_valid || out_status == ST_OK || out_value == '0,
    "value not zero on error status")
endmodule
`default_nettype wire

@@ rtl/iee_alu.sv @@
`default_nettype none
// shared arithmetic unit: add, subtract, multiply with a registered result, divide bit-serially
module iee_alu #(
  parameter int VW = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire iee_pkg::alu_req_t req,
  input  wire logic [VW-1:0]     a,
  input  wire logic [VW-1:0]     b,
  output iee_pkg::alu_rsp_t      rsp,
  output logic [VW-1:0]          result
);
  import iee_pkg::*;

  localparam int CW = $clog2(VW + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] div_r, div_nxt;
  logic          neg_r, neg_nxt;
  logic [VW-1:0] res_r, res_nxt;
  logic          done_r, done_nxt;
  logic          dz_r, dz_nxt;
  logic [VW-1:0] mag_a, mag_b;
  logic [VW:0]   trial;
  logic [VW-1:0] shifted;

  assign mag_a = a[VW-1] ? (~a + 1'b1) : a;
  assign mag_b = b[VW-1] ? (~b + 1'b1) : b;
  assign shifted = {rem_r[VW-2:0], quo_r[VW-1]};
  assign trial = {1'b0, shifted} - {1'b0, div_r};

  // sequencing of operations
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    dz_nxt   = 1'b0;
    if (busy_r) begin
      // one restoring step per cycle
      if (trial[VW]) begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[VW-2:0], 1'b0};
      end else begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_r[VW-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? (~quo_nxt + 1'b1) : quo_nxt;
      end
    end else if (req.start) begin
      unique case (req.op)
        OP_ADD: begin
          res_nxt = a + b;
          done_nxt = 1'b1;
        end
        OP_SUB: begin
          res_nxt = a - b;
          done_nxt = 1'b1;
        end
        OP_MUL: begin
          res_nxt = VW'(a * b);
          done_nxt = 1'b1;
        end
        default: begin
          if (b == '0) begin
            dz_nxt   = 1'b1;
            done_nxt = 1'b1;
          end else begin
            busy_nxt = 1'b1;
            cnt_nxt  = CW'(VW);
            rem_nxt  = '0;
            quo_nxt  = mag_a;
            div_nxt  = mag_b;
            neg_nxt  = a[VW-1] ^ b[VW-1];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      dz_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      dz_r   <= dz_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.div_zero = dz_r;
  assign result       = res_r;
endmodule
`default_nettype wire
